FILE: hdl/eye_scan_sweep_sequencer_macros.svh
// Assertion macros shared by the eye-scan sweep sequencer modules.
// IMPL checks the consequent in the same cycle, NEXT checks it in the following cycle.
`ifndef EYE_SCAN_SWEEP_SEQUENCER_MACROS_SVH
`define EYE_SCAN_SWEEP_SEQUENCER_MACROS_SVH
`ifndef SYNTHESIS
`define ESS_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("eye scan sequencer assertion failed");
`define ESS_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("eye scan sequencer assertion failed");
`else
`define ESS_ASSERT_IMPL(name, clk, rst, ante, cons)
`define ESS_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/ess_pkg.sv
`timescale 1ns / 1ps
package ess_pkg;

  localparam logic OP_POLL  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic [1:0] STAT_IDLE  = 2'd0;
  localparam logic [1:0] STAT_POINT = 2'd1;
  localparam logic [1:0] STAT_WAIT  = 2'd2;
  localparam logic [1:0] STAT_START = 2'd3;

  localparam logic [2:0] REG_HORZ_FIRST = 3'd0;
  localparam logic [2:0] REG_HORZ_LAST  = 3'd1;
  localparam logic [2:0] REG_HORZ_INC   = 3'd2;
  localparam logic [2:0] REG_VERT_FIRST = 3'd3;
  localparam logic [2:0] REG_VERT_LAST  = 3'd4;
  localparam logic [2:0] REG_VERT_INC   = 3'd5;

  localparam logic [4:0]  PRESCALE_MAX = 5'd31;
  localparam logic [15:0] COUNT_FULL   = 16'hffff;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_MUL    = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_SEARCH = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic shift;
    logic step;
    logic emit;
  } ess_cmd_t;

  typedef struct packed {
    logic op_start;
    logic found;
    logic out_free;
  } ess_stat_t;

endpackage

FILE: hdl/ess_ctrl.sv
`timescale 1ns / 1ps
`include "eye_scan_sweep_sequencer_macros.svh"
module ess_ctrl import ess_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  ess_stat_t stat,
  output ess_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.shift  = 1'b1;
        state_next = stat.op_start ? S_SEARCH : S_EMIT;
      end
      S_SEARCH: begin
        // Walk the prescale up one step per cycle until the span covers the target or the prescale reaches its maximum.
        if (stat.found) begin
          state_next = S_EMIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `ESS_ASSERT_NEXT(a_accept_to_mul, clk, rst, in_valid && !in_stall, state == S_MUL)
  `ESS_ASSERT_NEXT(a_emit_waits, clk, rst, state == S_EMIT && !stat.out_free, state == S_EMIT)
  `ESS_ASSERT_NEXT(a_poll_skips_search, clk, rst, state == S_SHIFT && !stat.op_start, state == S_EMIT)

endmodule

FILE: hdl/ess_datapath.sv
`timescale 1ns / 1ps
`include "eye_scan_sweep_sequencer_macros.svh"
module ess_datapath import ess_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [11:0]        cfg_data,
  input  logic               operation,
  input  logic               measure_done,
  input  logic [15:0]        error_total,
  input  logic [15:0]        sample_total,
  input  logic [6:0]         word_width,
  input  logic               dfe_mode,
  input  logic [55:0]        target_bits,
  input  ess_cmd_t           cmd,
  output ess_stat_t          stat,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [1:0]         status,
  output logic [15:0]        point_errors,
  output logic [55:0]        point_bits,
  output logic signed [11:0] point_x,
  output logic signed [7:0]  point_y,
  output logic               point_ut,
  output logic [11:0]        horz_code,
  output logic               vert_negative,
  output logic [6:0]         vert_magnitude,
  output logic               ut_setting,
  output logic               start_measure,
  output logic               scan_active
);

  // Configuration registers.
  logic signed [11:0] cfg_hf, cfg_hl;
  logic [10:0]        cfg_hi;
  logic signed [7:0]  cfg_vf, cfg_vl;
  logic [6:0]         cfg_vi;

  // Sweep state.
  logic               active, dfe, ut;
  logic [6:0]         width_bits;
  logic [4:0]         prescale;
  logic signed [11:0] horz, sw_hl;
  logic [10:0]        sw_hi;
  logic signed [7:0]  vert, sw_vf, sw_vl;
  logic [6:0]         sw_vi;

  // Captured item and arithmetic registers.
  logic        op_r, done_r, dfe_r;
  logic [15:0] err_r, sample_r;
  logic [6:0]  width_r;
  logic [55:0] target_r;
  logic [22:0] prod;
  logic [55:0] acc;
  logic [4:0]  cnt;

  logic        out_free;
  logic [15:0] mul_a;
  logic [6:0]  mul_b;
  logic [5:0]  shamt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_hf <= -12'sd32;
      cfg_hl <= 12'sd32;
      cfg_hi <= 11'd8;
      cfg_vf <= -8'sd127;
      cfg_vl <= 8'sd127;
      cfg_vi <= 7'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HORZ_FIRST: cfg_hf <= cfg_data;
        REG_HORZ_LAST:  cfg_hl <= cfg_data;
        REG_HORZ_INC:   cfg_hi <= cfg_data[10:0];
        REG_VERT_FIRST: cfg_vf <= cfg_data[7:0];
        REG_VERT_LAST:  cfg_vl <= cfg_data[7:0];
        REG_VERT_INC:   cfg_vi <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= operation;
      done_r   <= measure_done;
      err_r    <= error_total;
      sample_r <= sample_total;
      width_r  <= word_width;
      dfe_r    <= dfe_mode;
      target_r <= target_bits;
    end
  end

  // A start sizes the full counter, a poll sizes the reported sample count.
  assign mul_a = (op_r == OP_START) ? COUNT_FULL : sample_r;
  assign mul_b = (op_r == OP_START) ? width_r : width_bits;
  assign shamt = 6'd1 + {1'b0, ((op_r == OP_START) ? 5'd0 : prescale)};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= 23'(mul_a) * 23'(mul_b);
    end
    if (cmd.shift) begin
      acc <= 56'(prod) << shamt;
      cnt <= 5'd0;
    end else if (cmd.step) begin
      acc <= acc << 1;
      cnt <= cnt + 5'd1;
    end
  end

  assign out_free      = !out_valid || !out_stall;
  assign stat.op_start = (op_r == OP_START);
  assign stat.found    = (acc >= target_r) || (cnt == PRESCALE_MAX);
  assign stat.out_free = out_free;

  // Result and next sweep position.
  logic               act_n, ut_n, restart, show_set;
  logic signed [11:0] horz_n;
  logic signed [7:0]  vert_n;
  logic signed [8:0]  v_sum;
  logic signed [12:0] h_sum;
  logic signed [7:0]  v_step, v_neg;
  logic signed [11:0] h_step;
  logic [1:0]         r_status;
  logic [15:0]        r_err;
  logic [55:0]        r_bits;
  logic signed [11:0] r_x;
  logic signed [7:0]  r_y;
  logic               r_ut;

  assign v_sum  = {vert[7], vert} + $signed({2'b00, sw_vi});
  assign v_step = (v_sum > 9'sd127) ? 8'sd127 : v_sum[7:0];
  assign h_sum  = {horz[11], horz} + $signed({2'b00, sw_hi});
  assign h_step = (h_sum > 13'sd2047) ? 12'sd2047 : h_sum[11:0];

  always_comb begin
    act_n    = active;
    horz_n   = horz;
    vert_n   = vert;
    ut_n     = ut;
    restart  = 1'b0;
    show_set = 1'b0;
    r_status = STAT_IDLE;
    r_err    = '0;
    r_bits   = '0;
    r_x      = '0;
    r_y      = '0;
    r_ut     = 1'b0;
    if (op_r == OP_START) begin
      horz_n   = cfg_hf;
      vert_n   = cfg_vf;
      ut_n     = 1'b0;
      act_n    = 1'b1;
      restart  = 1'b1;
      show_set = 1'b1;
      r_status = STAT_START;
      r_bits   = acc;
    end else if (!active) begin
      r_status = STAT_IDLE;
    end else if (!done_r) begin
      r_status = STAT_WAIT;
    end else begin
      show_set = 1'b1;
      r_status = STAT_POINT;
      r_err    = err_r;
      r_bits   = acc;
      r_x      = horz;
      r_y      = vert;
      r_ut     = ut;
      // ut sign steps first, then the row, then the column.
      if (!ut && dfe) begin
        ut_n    = 1'b1;
        restart = 1'b1;
      end else begin
        ut_n = 1'b0;
      end
      if (!restart) begin
        if (vert < sw_vl) begin
          vert_n  = v_step;
          restart = 1'b1;
        end else begin
          vert_n = sw_vf;
        end
      end
      if (!restart) begin
        if (horz < sw_hl) begin
          horz_n  = h_step;
          restart = 1'b1;
        end else begin
          act_n = 1'b0;
        end
      end
    end
  end

  assign v_neg = -vert_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      dfe        <= 1'b0;
      width_bits <= 7'd16;
      prescale   <= 5'd0;
      horz       <= '0;
      vert       <= '0;
      ut         <= 1'b0;
      sw_hl      <= 12'sd32;
      sw_hi      <= 11'd8;
      sw_vf      <= -8'sd127;
      sw_vl      <= 8'sd127;
      sw_vi      <= 7'd8;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.emit) begin
        active <= act_n;
        horz   <= horz_n;
        vert   <= vert_n;
        ut     <= ut_n;
        if (op_r == OP_START) begin
          dfe        <= dfe_r;
          width_bits <= width_r;
          prescale   <= cnt;
          sw_hl      <= cfg_hl;
          sw_hi      <= cfg_hi;
          sw_vf      <= cfg_vf;
          sw_vl      <= cfg_vl;
          sw_vi      <= cfg_vi;
        end
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status         <= r_status;
      point_errors   <= r_err;
      point_bits     <= r_bits;
      point_x        <= r_x;
      point_y        <= r_y;
      point_ut       <= r_ut;
      horz_code      <= show_set ? horz_n : 12'd0;
      vert_negative  <= show_set && vert_n[7];
      if (!show_set) begin
        vert_magnitude <= 7'd0;
      end else if (vert_n == -8'sd128) begin
        vert_magnitude <= 7'd127;
      end else if (vert_n[7]) begin
        vert_magnitude <= v_neg[6:0];
      end else begin
        vert_magnitude <= vert_n[6:0];
      end
      ut_setting     <= show_set && ut_n;
      start_measure  <= restart;
      scan_active    <= act_n;
    end
  end

  `ESS_ASSERT_IMPL(a_step_below_max, clk, rst, cmd.step, cnt != PRESCALE_MAX)
  `ESS_ASSERT_IMPL(a_emit_when_free, clk, rst, cmd.emit, !out_valid || !out_stall)
  `ESS_ASSERT_IMPL(a_last_point_idle, clk, rst, out_valid && status == STAT_POINT && !scan_active, !start_measure && !ut_setting)

endmodule

FILE: hdl/eye_scan_sweep_sequencer.sv
`timescale 1ns / 1ps
// Eye-scan sweep sequencer. A start item picks the smallest prescale p (0..31) that
// covers the target bit count (31 if none does) and loads the first offsets; each
// finished poll emits one point and steps ut sign, then the vertical, then the
// horizontal offset. Items are taken one at a time: an item is captured, multiplied
// and shifted, a start then runs the prescale search, which doubles the span once per
// cycle, and the result register loads once the output is free. The next transfer in
// can be taken in the cycle after the result register loads. A result waiting on a
// stalled output does not block the next transfer in. Registers written on the
// configuration port take effect at the next start.
module eye_scan_sweep_sequencer import ess_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [11:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic               measure_done,
  input  logic [15:0]        error_total,
  input  logic [15:0]        sample_total,
  input  logic [6:0]         word_width,
  input  logic               dfe_mode,
  input  logic [55:0]        target_bits,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [15:0]        point_errors,
  output logic [55:0]        point_bits,
  output logic signed [11:0] point_x,
  output logic signed [7:0]  point_y,
  output logic               point_ut,
  output logic [11:0]        horz_code,
  output logic               vert_negative,
  output logic [6:0]         vert_magnitude,
  output logic               ut_setting,
  output logic               start_measure,
  output logic               scan_active
);

  ess_cmd_t  cmd;
  ess_stat_t stat;

  ess_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ess_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .operation      (operation),
    .measure_done   (measure_done),
    .error_total    (error_total),
    .sample_total   (sample_total),
    .word_width     (word_width),
    .dfe_mode       (dfe_mode),
    .target_bits    (target_bits),
    .cmd            (cmd),
    .stat           (stat),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .status         (status),
    .point_errors   (point_errors),
    .point_bits     (point_bits),
    .point_x        (point_x),
    .point_y        (point_y),
    .point_ut       (point_ut),
    .horz_code      (horz_code),
    .vert_negative  (vert_negative),
    .vert_magnitude (vert_magnitude),
    .ut_setting     (ut_setting),
    .start_measure  (start_measure),
    .scan_active    (scan_active)
  );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench import ess_pkg::*;;

  typedef struct packed {
    logic        op;
    logic        done;
    logic [15:0] err;
    logic [15:0] samp;
    logic [6:0]  width;
    logic        dfe;
    logic [55:0] target;
  } sweep_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] errors;
    logic [55:0] bits;
    logic [11:0] x;
    logic [7:0]  y;
    logic        ut;
    logic [11:0] hcode;
    logic        vneg;
    logic [6:0]  vmag;
    logic        ut_set;
    logic        start_m;
    logic        running;
  } sweep_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = OP_POLL;
  logic        measure_done = 1'b0;
  logic [15:0] error_total = '0;
  logic [15:0] sample_total = '0;
  logic [6:0]  word_width = 7'd16;
  logic        dfe_mode = 1'b0;
  logic [55:0] target_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [15:0] point_errors;
  logic [55:0] point_bits;
  logic signed [11:0] point_x;
  logic signed [7:0]  point_y;
  logic        point_ut;
  logic [11:0] horz_code;
  logic        vert_negative;
  logic [6:0]  vert_magnitude;
  logic        ut_setting;
  logic        start_measure;
  logic        scan_active;

  eye_scan_sweep_sequencer DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .measure_done(measure_done),
    .error_total(error_total), .sample_total(sample_total),
    .word_width(word_width), .dfe_mode(dfe_mode), .target_bits(target_bits),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .point_errors(point_errors), .point_bits(point_bits),
    .point_x(point_x), .point_y(point_y), .point_ut(point_ut),
    .horz_code(horz_code), .vert_negative(vert_negative),
    .vert_magnitude(vert_magnitude), .ut_setting(ut_setting),
    .start_measure(start_measure), .scan_active(scan_active)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Shadow of the register file and of the sweep state.
  logic [11:0] cfg_shadow [6];
  bit          sweep_active;
  bit          sweep_dfe;
  logic [6:0]  sweep_width;
  int          sweep_prescale;
  int          sweep_horz, sweep_vert;
  bit          sweep_ut;
  int          horz_end, horz_step, vert_start, vert_end, vert_step;

  sweep_result_t expected_results [$];
  int          mismatch_count = 0;
  bit          tx_steady = 0;
  bit          rx_steady = 0;

  task automatic reset_shadow();
    cfg_shadow[REG_HORZ_FIRST] = 12'(-32);
    cfg_shadow[REG_HORZ_LAST]  = 12'd32;
    cfg_shadow[REG_HORZ_INC]   = 12'd8;
    cfg_shadow[REG_VERT_FIRST] = 12'(8'(-127));
    cfg_shadow[REG_VERT_LAST]  = 12'd127;
    cfg_shadow[REG_VERT_INC]   = 12'd8;
    sweep_active = 0;
    sweep_dfe = 0;
    sweep_width = 7'd16;
    sweep_prescale = 0;
    sweep_horz = 0;
    sweep_vert = 0;
    sweep_ut = 0;
    horz_end = 32;
    horz_step = 8;
    vert_start = -127;
    vert_end = 127;
    vert_step = 8;
  endtask

  function automatic int clamp(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [55:0] scaled_bits(logic [15:0] cnt, int p);
    logic [63:0] prod;
    prod = 64'(cnt) * 64'(sweep_width);
    return 56'(prod << (1 + p));
  endfunction

  function automatic logic [11:0] reg_mask(logic [2:0] idx);
    case (idx) inside
      REG_HORZ_INC:                  return 12'h7ff;
      REG_VERT_FIRST, REG_VERT_LAST: return 12'h0ff;
      REG_VERT_INC:                  return 12'h07f;
      default:                       return 12'hfff;
    endcase
  endfunction

  task automatic fill_settings(inout sweep_result_t r);
    int mag;
    mag = sweep_vert < 0 ? -sweep_vert : sweep_vert;
    r.hcode = {sweep_horz < 0, 11'(sweep_horz)};
    r.vneg = sweep_vert < 0;
    r.vmag = 7'(mag > 127 ? 127 : mag);
    r.ut_set = sweep_ut;
  endtask

  task automatic advance_sweep(input sweep_item_t it, output sweep_result_t r);
    int p;
    bit restart;
    r = '0;
    restart = 0;
    if (it.op == OP_START) begin
      sweep_width = it.width;
      sweep_dfe = it.dfe;
      p = 0;
      while (p < int'(PRESCALE_MAX) && scaled_bits(COUNT_FULL, p) < it.target) p++;
      sweep_prescale = p;
      sweep_horz = int'($signed(cfg_shadow[REG_HORZ_FIRST]));
      horz_end   = int'($signed(cfg_shadow[REG_HORZ_LAST]));
      horz_step  = int'(cfg_shadow[REG_HORZ_INC]);
      vert_start = int'($signed(cfg_shadow[REG_VERT_FIRST][7:0]));
      vert_end   = int'($signed(cfg_shadow[REG_VERT_LAST][7:0]));
      vert_step  = int'(cfg_shadow[REG_VERT_INC]);
      sweep_vert = vert_start;
      sweep_ut = 0;
      sweep_active = 1;
      r.status = STAT_START;
      r.bits = scaled_bits(COUNT_FULL, p);
      fill_settings(r);
      r.start_m = 1'b1;
      r.running = 1'b1;
    end else if (!sweep_active) begin
      r.status = STAT_IDLE;
    end else if (!it.done) begin
      r.status = STAT_WAIT;
      r.running = 1'b1;
    end else begin
      r.status = STAT_POINT;
      r.errors = it.err;
      r.bits = scaled_bits(it.samp, sweep_prescale);
      r.x = 12'(sweep_horz);
      r.y = 8'(sweep_vert);
      r.ut = sweep_ut;
      // ut sign steps first, then the row, then the column.
      if (!sweep_ut && sweep_dfe) begin
        sweep_ut = 1;
        restart = 1;
      end else begin
        sweep_ut = 0;
      end
      if (!restart) begin
        if (sweep_vert < vert_end) begin
          sweep_vert = clamp(sweep_vert + vert_step, -128, 127);
          restart = 1;
        end else begin
          sweep_vert = vert_start;
        end
      end
      if (!restart) begin
        if (sweep_horz < horz_end) begin
          sweep_horz = clamp(sweep_horz + horz_step, -2048, 2047);
          restart = 1;
        end else begin
          sweep_active = 0;
        end
      end
      fill_settings(r);
      r.start_m = restart;
      r.running = sweep_active;
    end
  endtask

  function automatic string show(sweep_result_t r);
    return $sformatf({"st=%0d err=%h bits=%h x=%0d y=%0d ut=%b hc=%h vn=%b vm=%0d ",
                      "us=%b sm=%b run=%b"},
                     r.status, r.errors, r.bits, $signed(r.x), $signed(r.y), r.ut,
                     r.hcode, r.vneg, r.vmag, r.ut_set, r.start_m, r.running);
  endfunction

  always @(posedge clk) begin : check_results
    sweep_result_t seen, want;
    if (!rst && out_valid && !out_stall) begin
      seen = '{status, point_errors, point_bits, point_x, point_y, point_ut, horz_code,
               vert_negative, vert_magnitude, ut_setting, start_measure, scan_active};
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with none pending: %s", $realtime, show(seen));
      end else begin
        want = expected_results.pop_front();
        if (seen !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: result mismatch", $realtime);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(seen));
          end
        end
      end
    end
  end

  // Receiver backpressure: random free and stalled stretches, never stalled while rx_steady.
  always @(negedge clk) begin : drive_stall
    int left;
    if (left > 0) begin
      left--;
    end else if (out_stall || rx_steady || $urandom_range(0, 2) == 0) begin
      out_stall <= 1'b0;
      left = $urandom_range(0, 9) == 0 ? $urandom_range(30, 80) : $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b1;
      left = $urandom_range(0, 9) == 0 ? $urandom_range(15, 50) : $urandom_range(0, 2);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Called just after a falling edge; returns just after the falling edge that follows
  // the transfer, with in_valid still high.
  task automatic send_item(input sweep_item_t it);
    sweep_result_t r;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= it.op;
    measure_done <= it.done;
    error_total <= it.err;
    sample_total <= it.samp;
    word_width <= it.width;
    dfe_mode <= it.dfe;
    target_bits <= it.target;
    do @(posedge clk); while (in_stall);
    advance_sweep(it, r);
    expected_results.push_back(r);
    @(negedge clk);
  endtask

  function automatic sweep_item_t make_start(logic [6:0] w, logic dfe, logic [55:0] t);
    sweep_item_t it;
    it = 98'({$urandom, $urandom, $urandom, $urandom});
    it.op = OP_START;
    it.width = w;
    it.dfe = dfe;
    it.target = t;
    return it;
  endfunction

  function automatic sweep_item_t make_poll(logic done, logic [15:0] err, logic [15:0] samp);
    sweep_item_t it;
    it = 98'({$urandom, $urandom, $urandom, $urandom});
    it.op = OP_POLL;
    it.done = done;
    it.err = err;
    it.samp = samp;
    return it;
  endfunction

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic put_reg(logic [2:0] idx, int value);
    logic [11:0] data;
    data = (12'(value) & reg_mask(idx)) | (12'($urandom) & ~reg_mask(idx));
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_shadow[idx] = data & reg_mask(idx);
  endtask

  task automatic write_sweep(int hf, int hl, int hi, int vf, int vl, int vi);
    put_reg(REG_HORZ_FIRST, hf);
    put_reg(REG_HORZ_LAST, hl);
    put_reg(REG_HORZ_INC, hi);
    put_reg(REG_VERT_FIRST, vf);
    put_reg(REG_VERT_LAST, vl);
    put_reg(REG_VERT_INC, vi);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [6:0] pick_width();
    logic [6:0] widths [6] = '{7'd16, 7'd20, 7'd32, 7'd40, 7'd64, 7'd80};
    if ($urandom_range(0, 99) < 85) return widths[$urandom_range(0, 5)];
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic logic [55:0] pick_target(logic [6:0] w);
    int r;
    logic [63:0] boundary;
    r = $urandom_range(0, 9);
    if (r < 3) return 56'({$urandom, $urandom});
    if (r < 7) begin
      // Land on, just under or just over a prescale boundary.
      boundary = (64'(COUNT_FULL) * 64'(w)) << (1 + $urandom_range(0, 31));
      return 56'(boundary + 64'($urandom_range(0, 2)) - 64'd1);
    end
    return 56'($urandom_range(0, 1 << 20));
  endfunction

  function automatic logic [15:0] pick_count();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return COUNT_FULL;
    return 16'($urandom);
  endfunction

  task automatic test_idle_polls();
    send_item(make_poll(1'b0, 16'h1234, 16'h4321));
    send_item(make_poll(1'b1, COUNT_FULL, COUNT_FULL));
  endtask

  // Uses the register reset values; the later starts hit a running scan.
  task automatic test_start_restart();
    send_item(make_start(7'd16, 1'b0, 56'd0));
    send_item(make_poll(1'b0, 16'h0, 16'h0));
    send_item(make_poll(1'b1, COUNT_FULL, COUNT_FULL));
    send_item(make_poll(1'b1, 16'h0, 16'h0));
    send_item(make_start(7'd80, 1'b1, {56{1'b1}}));
    send_item(make_poll(1'b1, 16'h00ff, 16'hff00));
    send_item(make_poll(1'b1, 16'hff00, 16'h00ff));
    send_item(make_start(7'd0, 1'b0, 56'd1));
    send_item(make_poll(1'b1, 16'h5555, 16'haaaa));
    send_item(make_start(7'd127, 1'b1, {56{1'b1}}));
    send_item(make_poll(1'b1, 16'haaaa, COUNT_FULL));
  endtask

  // Most negative offsets with zero steps: the sweep never leaves its first point.
  task automatic test_zero_step();
    wait_idle();
    write_sweep(-2048, -2048, 0, -128, -127, 0);
    send_item(make_start(7'd40, 1'b1, 56'd3_000_000));
    repeat (3) send_item(make_poll(1'b1, pick_count(), pick_count()));
  endtask

  // Steps that overflow both offsets, through to the last point and past it.
  task automatic test_saturation();
    wait_idle();
    write_sweep(2040, 2047, 2047, 120, 127, 127);
    send_item(make_start(7'd20, 1'b0, 56'd2_621_400));
    repeat (5) send_item(make_poll(1'b1, pick_count(), pick_count()));
  endtask

  task automatic test_random_sweeps();
    int sent, len, hf, hl, hi, vf, vl, vi;
    bit counted;
    sweep_item_t it;
    sent = 0;
    while (sent < 1100) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0:       hi = 0;
        1:       hi = 2047;
        default: hi = $urandom_range(1, 96);
      endcase
      case ($urandom_range(0, 9))
        0:       hf = -2048;
        1:       hf = 2047;
        default: hf = int'($urandom_range(0, 4095)) - 2048;
      endcase
      hl = $urandom_range(0, 9) == 0 ? int'($urandom_range(0, 4095)) - 2048
                                     : clamp(hf + hi * int'($urandom_range(0, 3)), -2048, 2047);
      case ($urandom_range(0, 9))
        0:       vi = 0;
        1:       vi = 127;
        default: vi = $urandom_range(1, 40);
      endcase
      vf = int'($urandom_range(0, 255)) - 128;
      vl = $urandom_range(0, 9) == 0 ? int'($urandom_range(0, 255)) - 128
                                     : clamp(vf + vi * int'($urandom_range(0, 4)), -128, 127);
      write_sweep(hf, hl, hi, vf, vl, vi);
      tx_steady = $urandom_range(0, 4) == 0;
      rx_steady = $urandom_range(0, 4) == 0;
      len = $urandom_range(20, 90);
      repeat (len) begin
        if (!sweep_active)
          it = $urandom_range(0, 4) != 0 ? make_start(7'd0, 1'b0, 56'd0)
                                         : make_poll(1'($urandom), pick_count(), pick_count());
        else if ($urandom_range(0, 99) < 3)
          it = make_start(7'd0, 1'b0, 56'd0);
        else
          it = make_poll($urandom_range(0, 99) < 72, pick_count(), pick_count());
        if (it.op == OP_START) begin
          it.width = pick_width();
          it.dfe = 1'($urandom);
          it.target = pick_target(it.width);
        end
        counted = it.op == OP_START || sweep_active;
        send_item(it);
        if (counted) sent++;
      end
    end
    tx_steady = 0;
    rx_steady = 0;
  endtask

  initial begin
    reset_shadow();
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_idle_polls();
    test_start_restart();
    test_zero_step();
    test_saturation();
    test_random_sweeps();
    wait_idle();
    repeat (40) @(negedge clk);
    if (expected_results.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
